### rtl/spq_pkg.sv
// package for the sorted priority queue: field widths, result codes, cell control
`timescale 1ns / 1ps

package spq_pkg;

  // payload widths
  localparam int VAL_W = 32;
  localparam int PRI_W = 16;
  localparam int OCC_W = 5;

  // result status codes
  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // input action codes
  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_t;

  // control broadcast to every cell in the row
  typedef struct packed {
    logic push;  // insert the new entry, shifting larger ones right
    logic pop;   // remove the head, shifting everything left
  } cell_ctrl_t;

endpackage

### rtl/spq_cell.sv
// one storage cell of the sorted row: holds an entry and trades it with its neighbors
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    occupied,
  input  logic [VAL_W-1:0]        new_value,
  input  logic signed [PRI_W-1:0] new_pri,
  input  logic                    left_gt,
  input  logic [VAL_W-1:0]        left_value,
  input  logic signed [PRI_W-1:0] left_pri,
  input  logic [VAL_W-1:0]        right_value,
  input  logic signed [PRI_W-1:0] right_pri,
  output logic [VAL_W-1:0]        value,
  output logic signed [PRI_W-1:0] pri,
  output logic                    gt
);

  // the new entry belongs at or before this cell
  assign gt = !occupied || (new_pri < pri);

  // entry register, no reset: contents only matter below the fill count
  always_ff @(posedge clk) begin
    priority if (ctrl.push) begin
      if (left_gt) begin
        value <= left_value;
        pri   <= left_pri;
      end else if (gt) begin
        value <= new_value;
        pri   <= new_pri;
      end
    end else if (ctrl.pop) begin
      value <= right_value;
      pri   <= right_pri;
    end
  end

endmodule

### rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: cell row, fill count and result register
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries kept sorted by signed priority in a row
// of cells, smallest first; equal priorities leave in arrival order. Every input
// transfer yields exactly one result, registered at the edge that takes the item
// and offered from the next cycle. The queue takes one item per cycle while results
// are taken as they come: every cell compares its priority with the new one and
// shifts in the same cycle, so the whole cell row updates at once. The input is
// ready only while the result register is empty or its result leaves in the same
// cycle, so a stalled result holds off the input for as long as the stall lasts.
// An enqueue into a full queue is dropped with status full, a dequeue of an empty
// queue reports status empty; both leave the state alone.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // item_value[31:0], item_priority[47:32]
  input  logic [0:0]  s_tuser,   // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_value[31:0], out_priority[47:32],
                                 // occupancy[52:48], zero fill[55:53]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  action_t                 action;
  logic [VAL_W-1:0]        item_value;
  logic signed [PRI_W-1:0] item_priority;
  cell_ctrl_t              ctrl;
  status_t                 status;
  status_t                 status_next;
  logic [VAL_W-1:0]        out_value;
  logic [VAL_W-1:0]        out_value_next;
  logic signed [PRI_W-1:0] out_priority;
  logic signed [PRI_W-1:0] out_priority_next;

  logic [VAL_W-1:0]        cell_value [DEPTH];
  logic signed [PRI_W-1:0] cell_pri   [DEPTH];
  logic                    cell_gt    [DEPTH];

  // input unpacking and handshake
  assign action        = action_t'(s_tuser[0]);
  assign item_value    = s_tdata[31:0];
  assign item_priority = s_tdata[47:32];
  assign s_tready      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign full          = (count == CW'(DEPTH));
  assign empty         = (count == '0);

  // decode the transfer into cell control, status and next count
  always_comb begin
    ctrl              = '0;
    count_next        = count;
    status_next       = ST_ENQUEUED;
    out_value_next    = '0;
    out_priority_next = '0;
    unique case (action)
      ACT_ENQUEUE: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.push   = accept;
          count_next  = count + CW'(1);
          status_next = ST_ENQUEUED;
        end
      end
      ACT_DEQUEUE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.pop          = accept;
          count_next        = count - CW'(1);
          status_next       = ST_DEQUEUED;
          out_value_next    = cell_value[0];
          out_priority_next = cell_pri[0];
        end
      end
      default: status_next = ST_EMPTY;
    endcase
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_gt;
    logic [VAL_W-1:0]        left_value;
    logic signed [PRI_W-1:0] left_pri;
    logic [VAL_W-1:0]        right_value;
    logic signed [PRI_W-1:0] right_pri;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_value = item_value;
      assign left_pri   = item_priority;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_value = cell_value[i-1];
      assign left_pri   = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_pri   = cell_pri[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_pri   = cell_pri[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count),
      .new_value  (item_value),
      .new_pri    (item_priority),
      .left_gt    (left_gt),
      .left_value (left_value),
      .left_pri   (left_pri),
      .right_value(right_value),
      .right_pri  (right_pri),
      .value      (cell_value[i]),
      .pri        (cell_pri[i]),
      .gt         (cell_gt[i])
    );
  end

  // fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      out_value    <= out_value_next;
      out_priority <= out_priority_next;
    end
  end

  // result packing; occupancy shows the count after the transfer
  assign m_tuser = status;
  assign m_tdata = {3'b000, OCC_W'(count), out_priority, out_value};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> count == $past(count) + CW'(1))
    else $error("enqueue did not grow the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2) && DEPTH > 1) |-> cell_pri[0] <= cell_pri[DEPTH > 1 ? 1 : 0])
    else $error("head entry out of order");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_DEQUEUE && empty) |=> status == ST_EMPTY && count == '0)
    else $error("empty dequeue reported wrongly");
`endif

endmodule
